/* hw/rtl/rfq_pkg.sv */
package rfq_pkg;

  // Default geometry of the frame ring.
  localparam int unsigned QueueDepthDef = 8;
  localparam int unsigned MaxPayloadDef = 250;

  // Fixed field widths.
  localparam int unsigned ByteW   = 8;
  localparam int unsigned AddrW   = 48;
  localparam int unsigned LenW    = 8;
  localparam int unsigned StatusW = 2;
  localparam int unsigned DepthW  = 4;
  localparam int unsigned CountW  = 32;

  // Item opcodes.
  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_READ = 1'b1;

  // Push status codes.
  typedef enum logic [StatusW-1:0] {
    ST_TAKEN     = 2'd0,
    ST_COMMITTED = 2'd1,
    ST_DROP_FULL = 2'd2,
    ST_DROP_LEN  = 2'd3
  } rfq_status_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic push;        // push item accepted this cycle
    logic fetch;       // read item accepted, stores are read this cycle
    logic finish;      // fetched data is present, complete the read
    logic empty_read;  // read item accepted while no frame is held
  } rfq_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic empty;
  } rfq_stat_t;

endpackage

/* hw/rtl/rfq_if.sv */
interface rfq_in_if;
  logic                        valid;
  logic                        ready;
  logic                        cmd;
  logic [rfq_pkg::ByteW-1:0]   data_byte;
  logic [rfq_pkg::AddrW-1:0]   frame_src;
  logic                        frame_end;

  modport source (output valid, cmd, data_byte, frame_src, frame_end, input ready);
  modport sink   (input valid, cmd, data_byte, frame_src, frame_end, output ready);
endinterface

interface rfq_out_if;
  logic                          valid;
  logic                          ready;
  logic                          out_valid;
  logic [rfq_pkg::ByteW-1:0]     out_byte;
  logic [rfq_pkg::LenW-1:0]      out_len;
  logic [rfq_pkg::AddrW-1:0]     out_src;
  logic                          out_last;
  logic [rfq_pkg::StatusW-1:0]   push_status;
  logic [rfq_pkg::DepthW-1:0]    queue_depth;
  logic [rfq_pkg::CountW-1:0]    overflow_count;

  modport source (output valid, out_valid, out_byte, out_len, out_src, out_last,
                  push_status, queue_depth, overflow_count, input ready);
  modport sink   (input valid, out_valid, out_byte, out_len, out_src, out_last,
                  push_status, queue_depth, overflow_count, output ready);
endinterface

/* hw/rtl/rfq_ctrl.sv */
module rfq_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_cmd_i,
  output logic               in_ready_o,
  input  logic               out_ready_i,
  output logic               out_valid_o,
  input  rfq_pkg::rfq_stat_t stat_i,
  output rfq_pkg::rfq_cmd_t  cmd_o
);
  import rfq_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE  = 2'b01,
    S_FETCH = 2'b10
  } rfq_state_e;

  rfq_state_e state_q, state_d;
  logic       out_vld_q, out_vld_d;
  logic       accept;

  // A new item is taken only when its result has a free output register.
  assign in_ready_o  = (state_q == S_IDLE) && (!out_vld_q || out_ready_i);
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = out_vld_q;

  always_comb begin
    cmd_o.push       = accept && (in_cmd_i == CMD_PUSH);
    cmd_o.fetch      = accept && (in_cmd_i == CMD_READ) && !stat_i.empty;
    cmd_o.empty_read = accept && (in_cmd_i == CMD_READ) && stat_i.empty;
    cmd_o.finish     = (state_q == S_FETCH);
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (cmd_o.fetch) state_d = S_FETCH;
      S_FETCH: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (cmd_o.push || cmd_o.empty_read || cmd_o.finish) begin
      out_vld_d = 1'b1;
    end else if (out_ready_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      out_vld_q <= out_vld_d;
    end
  end

endmodule

/* hw/rtl/rfq_datapath.sv */
module rfq_datapath #(
  parameter int unsigned QUEUE_DEPTH = rfq_pkg::QueueDepthDef,
  parameter int unsigned MAX_PAYLOAD = rfq_pkg::MaxPayloadDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  rfq_pkg::rfq_cmd_t             cmd_i,
  output rfq_pkg::rfq_stat_t            stat_o,
  input  logic [rfq_pkg::ByteW-1:0]     data_byte_i,
  input  logic [rfq_pkg::AddrW-1:0]     frame_src_i,
  input  logic                          frame_end_i,
  output logic                          out_valid_o,
  output logic [rfq_pkg::ByteW-1:0]     out_byte_o,
  output logic [rfq_pkg::LenW-1:0]      out_len_o,
  output logic [rfq_pkg::AddrW-1:0]     out_src_o,
  output logic                          out_last_o,
  output logic [rfq_pkg::StatusW-1:0]   push_status_o,
  output logic [rfq_pkg::DepthW-1:0]    queue_depth_o,
  output logic [rfq_pkg::CountW-1:0]    overflow_count_o
);
  import rfq_pkg::*;

  localparam int unsigned StoreSize = QUEUE_DEPTH * MAX_PAYLOAD;
  localparam int unsigned MemAddrW  = (StoreSize > 1) ? $clog2(StoreSize) : 1;
  localparam int unsigned SlotW     = $clog2(QUEUE_DEPTH);
  localparam int unsigned CntW      = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned InLenW    = $clog2(MAX_PAYLOAD + 2);
  localparam int unsigned OffW      = $clog2(MAX_PAYLOAD + 1);
  localparam logic [SlotW-1:0]    LastSlot = SlotW'(QUEUE_DEPTH - 1);
  localparam logic [MemAddrW-1:0] SlotStep = MemAddrW'(MAX_PAYLOAD);
  localparam logic [InLenW-1:0]   MaxLen   = InLenW'(MAX_PAYLOAD);
  localparam logic [CntW-1:0]     FullCnt  = CntW'(QUEUE_DEPTH);

  // Stores
  logic [ByteW-1:0] pay_mem [StoreSize];
  logic [LenW-1:0]  len_mem [QUEUE_DEPTH];
  logic [AddrW-1:0] src_mem [QUEUE_DEPTH];
  logic [ByteW-1:0] pay_rd_q;
  logic [LenW-1:0]  len_rd_q;
  logic [AddrW-1:0] src_rd_q;

  // Ring state
  logic [SlotW-1:0]    wr_slot_q, wr_slot_d, rd_slot_q, rd_slot_d;
  logic [MemAddrW-1:0] wr_base_q, wr_base_d, rd_base_q, rd_base_d;
  logic [CntW-1:0]     frames_q, frames_d;
  logic [CountW-1:0]   dropped_q, dropped_d;
  logic [InLenW-1:0]   in_len_q, in_len_d, in_len_inc;
  logic [OffW-1:0]     rd_off_q, rd_off_d;
  logic                blocked_q, blocked_d;

  logic                full, pay_we, commit, rd_last;
  logic [MemAddrW-1:0] pay_wr_addr, pay_rd_addr;
  logic [8:0]          off_next;

  // Result register
  logic                out_valid_q, out_valid_d;
  logic [ByteW-1:0]    out_byte_q, out_byte_d;
  logic [LenW-1:0]     out_len_q, out_len_d;
  logic [AddrW-1:0]    out_src_q, out_src_d;
  logic                out_last_q, out_last_d;
  rfq_status_e         status_q, status_d;
  logic [DepthW-1:0]   depth_q, depth_d;
  logic [CountW-1:0]   ovf_q, ovf_d;
  logic                out_load;

  assign full         = (frames_q == FullCnt);
  assign stat_o.empty = (frames_q == '0);
  assign in_len_inc   = (in_len_q <= MaxLen) ? in_len_q + 1'b1 : in_len_q;
  assign pay_we       = cmd_i.push && !full && (in_len_q < MaxLen);
  assign pay_wr_addr  = wr_base_q + MemAddrW'(in_len_q);
  assign pay_rd_addr  = rd_base_q + MemAddrW'(rd_off_q);
  assign commit       = cmd_i.push && frame_end_i && (in_len_inc <= MaxLen) &&
                        !full && !blocked_q;
  assign off_next     = 9'(rd_off_q) + 9'd1;
  assign rd_last      = (off_next >= 9'(len_rd_q));

  always_ff @(posedge clk_i) begin
    if (pay_we) begin
      pay_mem[pay_wr_addr] <= data_byte_i;
    end
    if (commit) begin
      len_mem[wr_slot_q] <= LenW'(in_len_inc);
      src_mem[wr_slot_q] <= frame_src_i;
    end
    if (cmd_i.fetch) begin
      pay_rd_q <= pay_mem[pay_rd_addr];
      len_rd_q <= len_mem[rd_slot_q];
      src_rd_q <= src_mem[rd_slot_q];
    end
  end

  always_comb begin
    wr_slot_d = wr_slot_q;
    wr_base_d = wr_base_q;
    rd_slot_d = rd_slot_q;
    rd_base_d = rd_base_q;
    frames_d  = frames_q;
    dropped_d = dropped_q;
    in_len_d  = in_len_q;
    rd_off_d  = rd_off_q;
    blocked_d = blocked_q;

    out_valid_d = 1'b0;
    out_byte_d  = '0;
    out_len_d   = '0;
    out_src_d   = '0;
    out_last_d  = 1'b0;
    status_d    = ST_TAKEN;

    if (cmd_i.push) begin
      in_len_d = in_len_inc;
      if (full) begin
        blocked_d = 1'b1;
      end
      if (frame_end_i) begin
        if (in_len_inc > MaxLen) begin
          status_d = ST_DROP_LEN;
        end else if (full || blocked_q) begin
          status_d  = ST_DROP_FULL;
          dropped_d = dropped_q + 1'b1;
        end else begin
          status_d  = ST_COMMITTED;
          frames_d  = frames_q + 1'b1;
          if (wr_slot_q == LastSlot) begin
            wr_slot_d = '0;
            wr_base_d = '0;
          end else begin
            wr_slot_d = wr_slot_q + 1'b1;
            wr_base_d = wr_base_q + SlotStep;
          end
        end
        in_len_d  = '0;
        blocked_d = 1'b0;
      end
    end

    if (cmd_i.finish) begin
      out_valid_d = 1'b1;
      out_byte_d  = pay_rd_q;
      out_len_d   = len_rd_q;
      out_src_d   = src_rd_q;
      out_last_d  = rd_last;
      if (rd_last) begin
        rd_off_d = '0;
        frames_d = frames_q - 1'b1;
        if (rd_slot_q == LastSlot) begin
          rd_slot_d = '0;
          rd_base_d = '0;
        end else begin
          rd_slot_d = rd_slot_q + 1'b1;
          rd_base_d = rd_base_q + SlotStep;
        end
      end else begin
        rd_off_d = rd_off_q + 1'b1;
      end
    end

    depth_d  = DepthW'(frames_d);
    ovf_d    = dropped_d;
    out_load = cmd_i.push || cmd_i.finish || cmd_i.empty_read;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_slot_q <= '0;
      wr_base_q <= '0;
      rd_slot_q <= '0;
      rd_base_q <= '0;
      frames_q  <= '0;
      dropped_q <= '0;
      in_len_q  <= '0;
      rd_off_q  <= '0;
      blocked_q <= 1'b0;
    end else begin
      wr_slot_q <= wr_slot_d;
      wr_base_q <= wr_base_d;
      rd_slot_q <= rd_slot_d;
      rd_base_q <= rd_base_d;
      frames_q  <= frames_d;
      dropped_q <= dropped_d;
      in_len_q  <= in_len_d;
      rd_off_q  <= rd_off_d;
      blocked_q <= blocked_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_valid_q <= out_valid_d;
      out_byte_q  <= out_byte_d;
      out_len_q   <= out_len_d;
      out_src_q   <= out_src_d;
      out_last_q  <= out_last_d;
      status_q    <= status_d;
      depth_q     <= depth_d;
      ovf_q       <= ovf_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign out_byte_o       = out_byte_q;
  assign out_len_o        = out_len_q;
  assign out_src_o        = out_src_q;
  assign out_last_o       = out_last_q;
  assign push_status_o    = status_q;
  assign queue_depth_o    = depth_q;
  assign overflow_count_o = ovf_q;

endmodule

/* hw/rtl/rx_frame_ring_queue_unit.sv */
// Received-frame ring queue. Frames arrive on the input channel one payload byte per
// transfer (cmd push) and are stored into the next free slot of a ring of QUEUE_DEPTH
// slots of MAX_PAYLOAD bytes each; the transfer carrying frame_end commits the frame
// with its source address, or drops it when its length is bad or the ring was full.
// A read transfer (cmd read) returns the next byte of the oldest frame together with
// its length, source and a last mark; the slot is freed after its last byte.
// Every input transfer produces exactly one output transfer.
// A push result is registered in the output register; a read result passes the
// registered read port of the stores and then the output register. A push can be
// taken every cycle while the receiver takes the results; a read holds off the next
// input transfer until its fetched data has been loaded into the output register.
// Reset clears the ring pointers, frame count, overflow counter and the partial
// frame; the stores themselves are not cleared since only committed slots are read.
// When the receiver stalls, the result is held in the output register and the input
// channel drops ready until that result has been transferred.
module rx_frame_ring_queue_unit #(
  parameter int unsigned QUEUE_DEPTH = rfq_pkg::QueueDepthDef,
  parameter int unsigned MAX_PAYLOAD = rfq_pkg::MaxPayloadDef
) (
  input logic        clk_i,
  input logic        rst_ni,
  rfq_in_if.sink     in_i,
  rfq_out_if.source  out_o
);
  import rfq_pkg::*;

  rfq_cmd_t  cmd;
  rfq_stat_t stat;

  // Controller: handshakes, the fetch state and the output valid flag.
  rfq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_cmd_i    (in_i.cmd),
    .in_ready_o  (in_i.ready),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // Datapath: stores, ring pointers, counters and the result register.
  rfq_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .data_byte_i      (in_i.data_byte),
    .frame_src_i      (in_i.frame_src),
    .frame_end_i      (in_i.frame_end),
    .out_valid_o      (out_o.out_valid),
    .out_byte_o       (out_o.out_byte),
    .out_len_o        (out_o.out_len),
    .out_src_o        (out_o.out_src),
    .out_last_o       (out_o.out_last),
    .push_status_o    (out_o.push_status),
    .queue_depth_o    (out_o.queue_depth),
    .overflow_count_o (out_o.overflow_count)
  );

endmodule

/* hw/rtl/rfq_checker.sv */
module rfq_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_i,
  input logic                          in_cmd_i,
  input logic                          out_valid_i,
  input logic                          out_ready_i,
  input logic                          res_valid_i,
  input logic                          res_last_i,
  input logic [rfq_pkg::ByteW-1:0]     res_byte_i,
  input logic [rfq_pkg::StatusW-1:0]   res_status_i
);
  import rfq_pkg::*;

  // A stalled result stays offered with the same byte.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(res_byte_i))
    else $error("result dropped or changed while stalled");

  // No input transfer while a stalled result occupies the output.
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |-> !(out_valid_i && !out_ready_i))
    else $error("input taken while output stalled");

  // A push result is offered in the next cycle.
  a_push_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && (in_cmd_i == CMD_PUSH) |=> out_valid_i)
    else $error("push result late");

  // Read results carry no push status and a last mark only with a byte.
  a_read_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (res_valid_i || res_last_i) |->
      res_valid_i && (res_status_i == ST_TAKEN))
    else $error("inconsistent read result fields");

endmodule

bind rx_frame_ring_queue_unit rfq_checker u_rfq_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .in_cmd_i     (in_i.cmd),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .res_valid_i  (out_o.out_valid),
  .res_last_i   (out_o.out_last),
  .res_byte_i   (out_o.out_byte),
  .res_status_i (out_o.push_status)
);

/* tb/sv/rx_frame_ring_queue_unit_test.sv */
// Self-checking testbench for the received-frame ring queue.
//
// An initial block builds the whole stimulus as a queue of pending input items.
// A clocked driver offers them on the input channel, and a clocked monitor takes
// results from the output channel. Every input transfer is run through a local
// model of the ring when the block accepts it. That gives exactly one expected
// result, which the monitor compares field by field with the next output transfer.
module rx_frame_ring_queue_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import rfq_pkg::*;

  localparam int unsigned Slots     = QueueDepthDef;
  localparam int unsigned SlotBytes = MaxPayloadDef;
  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned ReportMax  = 10;

  typedef struct packed {
    logic               cmd;
    logic [ByteW-1:0]   data_byte;
    logic [AddrW-1:0]   frame_src;
    logic               frame_end;
  } frame_item_t;

  typedef struct packed {
    logic               out_valid;
    logic [ByteW-1:0]   out_byte;
    logic [LenW-1:0]    out_len;
    logic [AddrW-1:0]   out_src;
    logic               out_last;
    rfq_status_e        push_status;
    logic [DepthW-1:0]  queue_depth;
    logic [CountW-1:0]  overflow_count;
  } frame_result_t;

  logic clk_i;
  logic rst_ni;

  rfq_in_if  in_ch ();
  rfq_out_if out_ch ();

  rx_frame_ring_queue_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  frame_item_t   pending_items[$];
  frame_result_t expected_results[$];

  int unsigned fault_count  = 0;
  int unsigned results_seen = 0;
  int unsigned cycle_count  = 0;

  // Local copy of the ring. The stores start undefined, just as in hardware.
  // The stimulus only reads slots that were committed, so every read hits an
  // entry that has been written.
  logic [ByteW-1:0] ring_bytes [Slots*SlotBytes];
  logic [LenW-1:0]  ring_len   [Slots];
  logic [AddrW-1:0] ring_src   [Slots];
  int unsigned      head_slot   = 0;  // slot that the arriving frame fills
  int unsigned      tail_slot   = 0;  // slot that reads drain
  int unsigned      frames_held = 0;
  int unsigned      arrive_len  = 0;  // saturates one past the slot size
  int unsigned      drain_pos   = 0;
  logic [CountW-1:0] full_drops = '0;
  bit               arrive_blocked = 1'b0;

  // Advances the local ring by one accepted item and returns the result that
  // the block has to produce for it.
  function automatic frame_result_t advance_ring(frame_item_t it);
    frame_result_t r;
    bit            full;
    int unsigned   len;
    r = '0;
    if (it.cmd == CMD_PUSH) begin
      full = frames_held >= Slots;
      // While the ring is full the head slot is still being drained, so the byte
      // is not stored. The frame is marked and dropped at its end, even if a slot
      // opens up before that.
      if (full) begin
        arrive_blocked = 1'b1;
      end else if (arrive_len < SlotBytes) begin
        ring_bytes[head_slot*SlotBytes + arrive_len] = it.data_byte;
      end
      if (arrive_len <= SlotBytes) begin
        arrive_len++;
      end
      if (it.frame_end) begin
        // The length check wins over the full check, and it leaves the
        // overflow counter alone.
        if (arrive_len > SlotBytes) begin
          r.push_status = ST_DROP_LEN;
        end else if (full || arrive_blocked) begin
          r.push_status = ST_DROP_FULL;
          full_drops++;
        end else begin
          ring_len[head_slot] = arrive_len[LenW-1:0];
          ring_src[head_slot] = it.frame_src;
          head_slot = (head_slot + 1) % Slots;
          frames_held++;
          r.push_status = ST_COMMITTED;
        end
        arrive_len     = 0;
        arrive_blocked = 1'b0;
      end
    end else if (frames_held != 0) begin
      // A read on an empty ring gives a result with no byte, only depth and overflow count, and changes nothing.
      len           = ring_len[tail_slot];
      r.out_valid   = 1'b1;
      r.out_byte    = ring_bytes[tail_slot*SlotBytes + drain_pos];
      r.out_len     = ring_len[tail_slot];
      r.out_src     = ring_src[tail_slot];
      if (drain_pos + 1 >= len) begin
        r.out_last  = 1'b1;
        drain_pos   = 0;
        tail_slot   = (tail_slot + 1) % Slots;
        frames_held--;
      end else begin
        drain_pos++;
      end
    end
    r.queue_depth    = frames_held[DepthW-1:0];
    r.overflow_count = full_drops;
    return r;
  endfunction

  // Idle cycles per transfer. Each side now and then flips into a calm stretch
  // with no idling at all, so back-to-back traffic is covered too.
  function automatic int unsigned draw_gap(inout bit calm);
    if ($urandom_range(0, 39) == 0) begin
      calm = !calm;
    end
    return calm ? 0 : $urandom_range(0, 12);
  endfunction

  function automatic logic [AddrW-1:0] rand_addr();
    return AddrW'({$urandom, $urandom});
  endfunction

  task automatic add_push(input logic [ByteW-1:0] b, input logic [AddrW-1:0] src,
                          input logic last);
    frame_item_t it;
    it.cmd       = CMD_PUSH;
    it.data_byte = b;
    it.frame_src = src;
    it.frame_end = last;
    pending_items.push_back(it);
  endtask

  // Read items carry random junk in the fields the block ignores on a read.
  task automatic add_reads(input int unsigned n);
    frame_item_t it;
    repeat (n) begin
      it.cmd       = CMD_READ;
      it.data_byte = ByteW'($urandom);
      it.frame_src = rand_addr();
      it.frame_end = 1'($urandom_range(0, 1));
      pending_items.push_back(it);
    end
  endtask

  // One frame of random bytes. Before each byte, reads are slipped in with the
  // given chance, so frames are drained while others arrive.
  task automatic push_frame(input int unsigned len, input int unsigned read_pct);
    for (int unsigned i = 0; i < len; i++) begin
      while ($urandom_range(0, 99) < read_pct) begin
        add_reads(1);
      end
      add_push(ByteW'($urandom), rand_addr(), i == len - 1);
    end
  endtask

  task automatic compare_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
    if (want !== got) begin
      fault_count++;
      if (fault_count <= ReportMax) begin
        $display("result %0d: %s expected 0x%0h, got 0x%0h", results_seen, name,
                 want, got);
      end
    end
  endtask

  // Clock, and the starting values of every input of the block.
  initial begin
    clk_i = 1'b0;
    rst_ni = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.cmd       = CMD_PUSH;
    in_ch.data_byte = '0;
    in_ch.frame_src = '0;
    in_ch.frame_end = 1'b0;
    out_ch.ready    = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Driver. The model is advanced at the edge where a transfer happens. A new
  // item, or an idle cycle, is put up whenever the current one has gone.
  frame_item_t next_item;
  int unsigned tx_gap;
  bit          tx_calm = 1'b0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_ch.valid <= 1'b0;
      tx_gap      <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        expected_results.push_back(advance_ring({in_ch.cmd, in_ch.data_byte,
                                                 in_ch.frame_src, in_ch.frame_end}));
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (tx_gap != 0) begin
          tx_gap      <= tx_gap - 1;
          in_ch.valid <= 1'b0;
        end else if (pending_items.size() != 0) begin
          next_item        = pending_items.pop_front();
          in_ch.cmd       <= next_item.cmd;
          in_ch.data_byte <= next_item.data_byte;
          in_ch.frame_src <= next_item.frame_src;
          in_ch.frame_end <= next_item.frame_end;
          in_ch.valid     <= 1'b1;
          tx_gap          <= draw_gap(tx_calm);
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Long hold-off of the receiver, once, well into the run. The driver keeps
  // offering items, so the block has to hold its result and stall its input.
  int unsigned hold_left;
  bit          hold_done;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && results_seen >= 200) begin
      hold_left <= 400;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Monitor. Each output transfer is checked against the oldest expectation.
  // After each transfer ready is held low for a random number of cycles.
  frame_result_t want_result;
  int unsigned   rx_wait;
  int unsigned   rx_draw;
  bit            rx_calm = 1'b0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
      rx_wait      <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_results.size() == 0) begin
          fault_count++;
          if (fault_count <= ReportMax) begin
            $display("result %0d: transfer with no expectation waiting", results_seen);
          end
        end else begin
          want_result = expected_results.pop_front();
          compare_field("out_valid", 64'(want_result.out_valid), 64'(out_ch.out_valid));
          compare_field("out_byte", 64'(want_result.out_byte), 64'(out_ch.out_byte));
          compare_field("out_len", 64'(want_result.out_len), 64'(out_ch.out_len));
          compare_field("out_src", 64'(want_result.out_src), 64'(out_ch.out_src));
          compare_field("out_last", 64'(want_result.out_last), 64'(out_ch.out_last));
          compare_field("push_status", 64'(want_result.push_status),
                        64'(out_ch.push_status));
          compare_field("queue_depth", 64'(want_result.queue_depth),
                        64'(out_ch.queue_depth));
          compare_field("overflow_count", 64'(want_result.overflow_count),
                        64'(out_ch.overflow_count));
        end
        results_seen <= results_seen + 1;
        rx_draw       = draw_gap(rx_calm);
        rx_wait      <= rx_draw;
        out_ch.ready <= (rx_draw == 0) && (hold_left == 0);
      end else if (rx_wait != 0) begin
        rx_wait      <= rx_wait - 1;
        out_ch.ready <= (rx_wait == 1) && (hold_left == 0);
      end else begin
        out_ch.ready <= (hold_left == 0);
      end
    end
  end

  // Watchdog: a run that hangs counts as a failure.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("rx_frame_ring_queue_unit_test: errors");
      $finish;
    end
  end

  // Stimulus, then the end of the run.
  initial begin : stimulus_and_end
    int unsigned phase_frames;
    int unsigned read_pct;
    int unsigned pick;
    int unsigned len;

    // Directed part. First a read of an empty ring, then a one-byte frame with
    // an all-ones byte and source, and a three-byte frame with edge bytes and a
    // zero-heavy source.
    add_reads(1);
    add_push(8'hFF, '1, 1'b1);
    add_push(8'h00, '0, 1'b0);
    add_push(8'h80, '0, 1'b0);
    add_push(8'h7F, 48'h8000_0000_0001, 1'b1);
    // Drain both frames, then one more read that finds the ring empty.
    add_reads(5);
    // Nine one-byte frames: eight fill the ring and the ninth is dropped as full.
    for (int i = 0; i < 9; i++) begin
      add_push(8'(i), rand_addr(), 1'b1);
    end
    // A frame starts while the ring is full, a read frees a slot halfway, and
    // the frame is still dropped at its end.
    add_push(8'h55, rand_addr(), 1'b0);
    add_reads(1);
    add_push(8'hAA, rand_addr(), 1'b1);

    // Random part. Empty the ring, then one frame of the largest length and one
    // just too long. Its bytes past the slot size must not spill into the next
    // slot. Read the large frame back in full.
    add_reads(10);
    push_frame(SlotBytes, 0);
    push_frame(SlotBytes + 1 + $urandom_range(0, 3), 0);
    add_reads(SlotBytes + 2);

    // Phases with different read densities. Some fill the ring and drop frames
    // as full, others drain it down to empty reads.
    while (pending_items.size() < 820) begin
      phase_frames = $urandom_range(1, 6);
      pick = $urandom_range(0, 3);
      read_pct = (pick == 0) ? 0 : (pick == 1) ? 15 : (pick == 2) ? 40 : 70;
      repeat (phase_frames) begin
        pick = $urandom_range(0, 99);
        if (pick < 60) begin
          len = $urandom_range(1, 6);
        end else if (pick < 85) begin
          len = $urandom_range(7, 24);
        end else begin
          len = $urandom_range(25, 60);
        end
        push_frame(len, read_pct);
      end
      if ($urandom_range(0, 9) < 3) begin
        add_reads($urandom_range(1, 25));
      end
    end

    @(posedge rst_ni);
    while (pending_items.size() != 0 || in_ch.valid || expected_results.size() != 0) begin
      @(posedge clk_i);
    end
    // A read result passes the store read register and the output register. Give any
    // stray extra result time to show up.
    repeat (8) @(posedge clk_i);
    if (fault_count == 0) begin
      $display("rx_frame_ring_queue_unit_test: clean");
    end else begin
      $display("rx_frame_ring_queue_unit_test: errors");
    end
    $finish;
  end

endmodule
